// ----- hdl/dxc_pkg.sv -----
// Shared types and constants of the decimal expression calculator.
// Used by dxc_front, dxc_queue, dxc_back and the top level; no dependencies.
package dxc_pkg;

  // Status codes of a result transaction
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_FIRST  = 3'd1;
  localparam logic [2:0] ST_NO_OP      = 3'd2;
  localparam logic [2:0] ST_BAD_OP     = 3'd3;
  localparam logic [2:0] ST_BAD_SECOND = 3'd4;
  localparam logic [2:0] ST_TRAILING   = 3'd5;
  localparam logic [2:0] ST_MATH       = 3'd6;

  // Operator codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  // Character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } char_item_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic [2:0]  status;
  } result_item_t;

  // One parsed line, handed from the parser to the execution unit
  typedef struct packed {
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [1:0]  op;
    logic [2:0]  status;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- hdl/dxc_front.sv -----
// Character parser of the calculator: phase machine, checked digit accumulation.
// Depends on dxc_pkg; feeds parsed lines into dxc_queue.
module dxc_front import dxc_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_item_t char_item,
  input  q_status_t  q_stat,
  output logic       push,
  output job_t       push_job
);

  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [2:0] {
    PH_START,
    PH_NUM1,
    PH_AFTER1,
    PH_AFTEROP,
    PH_NUM2,
    PH_TRAIL
  } phase_t;

  phase_t          phase, phase_next;
  logic [63:0]     acc, acc_next;
  logic [CntW-1:0] cnt, cnt_next;
  logic [63:0]     first_op, first_op_next;
  logic [1:0]      op_code, op_code_next;
  logic [2:0]      err, err_next;

  logic            accept;
  logic [7:0]      c;
  logic [7:0]      c_off;
  logic            digit_hit;
  logic            is_space;
  logic            is_op;
  logic [1:0]      op_val;
  logic [67:0]     mac;
  logic            digit_ok;
  logic [2:0]      fin_status;

  assign char_stall = q_stat.full;
  assign accept     = char_valid && !q_stat.full;
  assign c          = char_item.char_code;
  assign c_off      = c - CH_0;
  assign digit_hit  = (c >= CH_0) && (c <= CH_9);
  assign is_space   = (c == CH_SPACE);

  // acc * 10 + d, with four guard bits to catch anything above 2^64-1
  assign mac = {acc, 3'b000} + {2'b00, acc, 1'b0} + {64'd0, c_off[3:0]};
  assign digit_ok = (cnt < CntW'(MAX_DIGITS)) && (mac[67:64] == 4'd0);

  always_comb begin
    unique case (c)
      CH_PLUS: begin
        is_op  = 1'b1;
        op_val = OP_ADD;
      end
      CH_MINUS: begin
        is_op  = 1'b1;
        op_val = OP_SUB;
      end
      CH_STAR: begin
        is_op  = 1'b1;
        op_val = OP_MUL;
      end
      default: begin
        is_op  = 1'b0;
        op_val = OP_ADD;
      end
    endcase
  end

  always_comb begin
    if (err != ST_OK) begin
      fin_status = err;
    end else begin
      unique case (phase) inside
        PH_START:            fin_status = ST_BAD_FIRST;
        PH_NUM1, PH_AFTER1:  fin_status = ST_NO_OP;
        PH_AFTEROP:          fin_status = ST_BAD_SECOND;
        default:             fin_status = ST_OK;
      endcase
    end
  end

  assign push_job = '{operand_a: first_op, operand_b: acc, op: op_code, status: fin_status};

  always_comb begin
    phase_next    = phase;
    acc_next      = acc;
    cnt_next      = cnt;
    first_op_next = first_op;
    op_code_next  = op_code;
    err_next      = err;
    push          = 1'b0;
    if (accept) begin
      if (char_item.end_of_line) begin
        // Hand the line over and start afresh
        push          = 1'b1;
        phase_next    = PH_START;
        acc_next      = '0;
        cnt_next      = '0;
        first_op_next = '0;
        op_code_next  = OP_ADD;
        err_next      = ST_OK;
      end else if (err == ST_OK) begin
        unique case (phase)
          PH_START: begin
            if (digit_hit) begin
              acc_next   = {60'd0, c_off[3:0]};
              cnt_next   = CntW'(1);
              phase_next = PH_NUM1;
            end else if (!is_space) begin
              err_next = ST_BAD_FIRST;
            end
          end
          PH_NUM1: begin
            if (digit_hit) begin
              if (digit_ok) begin
                acc_next = mac[63:0];
                cnt_next = cnt + CntW'(1);
              end else begin
                err_next = ST_BAD_FIRST;
              end
            end else begin
              first_op_next = acc;
              acc_next      = '0;
              cnt_next      = '0;
              phase_next    = PH_AFTER1;
              if (!is_space) begin
                if (is_op) begin
                  op_code_next = op_val;
                  phase_next   = PH_AFTEROP;
                end else begin
                  err_next = ST_BAD_OP;
                end
              end
            end
          end
          PH_AFTER1: begin
            if (!is_space) begin
              if (is_op) begin
                op_code_next = op_val;
                phase_next   = PH_AFTEROP;
              end else begin
                err_next = ST_BAD_OP;
              end
            end
          end
          PH_AFTEROP: begin
            if (digit_hit) begin
              acc_next   = {60'd0, c_off[3:0]};
              cnt_next   = CntW'(1);
              phase_next = PH_NUM2;
            end else if (!is_space) begin
              err_next = ST_BAD_SECOND;
            end
          end
          PH_NUM2: begin
            if (digit_hit) begin
              if (digit_ok) begin
                acc_next = mac[63:0];
                cnt_next = cnt + CntW'(1);
              end else begin
                err_next = ST_BAD_SECOND;
              end
            end else if (is_space) begin
              phase_next = PH_TRAIL;
            end else begin
              err_next = ST_TRAILING;
            end
          end
          default: begin
            if (!is_space) err_next = ST_TRAILING;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      acc      <= '0;
      cnt      <= '0;
      first_op <= '0;
      op_code  <= OP_ADD;
      err      <= ST_OK;
    end else begin
      phase    <= phase_next;
      acc      <= acc_next;
      cnt      <= cnt_next;
      first_op <= first_op_next;
      op_code  <= op_code_next;
      err      <= err_next;
    end
  end

endmodule

// ----- hdl/dxc_queue.sv -----
// Two-entry queue of parsed lines between parser and execution unit.
// Depends on dxc_pkg.
module dxc_queue import dxc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      pop_job,
  output q_status_t q_stat
);

  job_t head_job;
  job_t spare_job;
  logic head_vld;
  logic spare_vld;

  assign pop_job      = head_job;
  assign q_stat.full  = spare_vld;
  assign q_stat.empty = !head_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld  <= 1'b0;
      spare_vld <= 1'b0;
    end else begin
      if (pop) begin
        if (spare_vld) begin
          head_job <= spare_job;
          if (push) begin
            spare_job <= push_job;
          end else begin
            spare_vld <= 1'b0;
          end
        end else if (push) begin
          head_job <= push_job;
        end else begin
          head_vld <= 1'b0;
        end
      end else if (push) begin
        if (!head_vld) begin
          head_job <= push_job;
          head_vld <= 1'b1;
        end else begin
          spare_job <= push_job;
          spare_vld <= 1'b1;
        end
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !q_stat.full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !q_stat.empty)
    else $error("pop from empty queue");
  a_fill_order: assert property (@(posedge clk) disable iff (rst) spare_vld |-> head_vld)
    else $error("spare entry held without head entry");

endmodule

// ----- hdl/dxc_back.sv -----
// Execution unit: checked add, subtract and a four-step 32x32 multiply.
// Depends on dxc_pkg; pulls parsed lines from dxc_queue and drives the result register.
module dxc_back import dxc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  q_status_t    q_stat,
  input  job_t         pop_job,
  output logic         pop,
  output logic         res_valid,
  input  logic         res_stall,
  output result_item_t res_item
);

  localparam logic [2:0] MulIssue = 3'd4;
  localparam logic [2:0] MulDone  = 3'd5;

  typedef enum logic {
    B_IDLE,
    B_MUL
  } back_state_t;

  back_state_t  state;
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic [2:0]   step;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic         pp_vld;
  logic [127:0] prod;

  logic         out_free;
  logic         direct;
  logic         res_load;
  logic [64:0]  sum65;
  logic [64:0]  dif65;
  result_item_t direct_res;
  result_item_t mul_res;
  logic [31:0]  mul_x;
  logic [31:0]  mul_y;

  assign out_free = !res_valid || !res_stall;
  assign pop      = (state == B_IDLE) && !q_stat.empty && out_free;
  assign direct   = (pop_job.status != ST_OK) || (pop_job.op != OP_MUL);
  assign res_load = ((state == B_IDLE) && pop && direct) ||
                    ((state == B_MUL) && (step == MulDone) && out_free);

  assign sum65 = {1'b0, pop_job.operand_a} + {1'b0, pop_job.operand_b};
  assign dif65 = {1'b0, pop_job.operand_a} - {1'b0, pop_job.operand_b};

  always_comb begin
    direct_res = '{result_value: 64'd0, status: ST_MATH};
    if (pop_job.status != ST_OK) begin
      direct_res.status = pop_job.status;
    end else begin
      unique case (pop_job.op)
        OP_ADD: if (!sum65[64]) direct_res = '{result_value: sum65[63:0], status: ST_OK};
        OP_SUB: if (!dif65[64]) direct_res = '{result_value: dif65[63:0], status: ST_OK};
        default: direct_res = '{result_value: 64'd0, status: ST_MATH};
      endcase
    end
  end

  // Step bit 0 picks the half of a, bit 1 the half of b
  assign mul_x = step[0] ? ma[63:32] : ma[31:0];
  assign mul_y = step[1] ? mb[63:32] : mb[31:0];

  always_comb begin
    if (prod[127:64] != 64'd0) begin
      mul_res = '{result_value: 64'd0, status: ST_MATH};
    end else begin
      mul_res = '{result_value: prod[63:0], status: ST_OK};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
      step      <= '0;
      pp_vld    <= 1'b0;
    end else begin
      // Load a finished result, or drop the one just taken
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      pp_vld <= (state == B_MUL) && (step < MulIssue);
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            if (direct) begin
              res_item <= direct_res;
            end else begin
              state <= B_MUL;
              ma    <= pop_job.operand_a;
              mb    <= pop_job.operand_b;
              step  <= '0;
              prod  <= '0;
            end
          end
        end
        B_MUL: begin
          if (step < MulIssue) begin
            pp    <= mul_x * mul_y;
            pp_sh <= {1'b0, step[0]} + {1'b0, step[1]};
          end
          if (pp_vld) prod <= prod + ({64'd0, pp} << {pp_sh, 5'b00000});
          if (step != MulDone) begin
            step <= step + 3'd1;
          end else if (out_free) begin
            res_item <= mul_res;
            state    <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
      res_valid && (res_item.status != ST_OK) |-> res_item.result_value == 64'd0)
    else $error("error result carries a nonzero value");
  a_mul_stays: assert property (@(posedge clk) disable iff (rst)
      (state == B_MUL) && (step != MulDone) |=> state == B_MUL)
    else $error("multiply left before its last step");
  a_mul_delivers: assert property (@(posedge clk) disable iff (rst)
      (state == B_MUL) && (step == MulDone) && out_free |=> res_valid && (state == B_IDLE))
    else $error("finished product not delivered");

endmodule

// ----- hdl/decimal_expression_calculator_unit.sv -----
// Decimal expression calculator, top level.
// Depends on dxc_pkg, dxc_front, dxc_queue and dxc_back.
//
// Usage: the char channel (char_valid/char_stall/char_item) carries one character
// transaction per cycle; a transaction with end_of_line set closes the line and
// causes exactly one res transaction (res_valid/res_stall/res_item) holding the
// 64-bit sum, difference or product, or a status code with a zero value.
// Throughput: one character per cycle. The parser stalls only while the
// two-line queue is full, i.e. while the execution unit works on earlier lines.
// From the terminator to res_valid an add, subtract or error result passes the
// queue register and then the result register; a multiply also steps through the
// multiply state (four 32x32 partial products, each registered and then summed
// into a 128-bit product). The shared multiplier takes no new line until it is done.
// When the receiver asserts res_stall the result register holds; the queue
// absorbs two more lines, after which char_stall rises.
// Reset (rst, synchronous, active high) drops queued lines and any pending
// result and returns the parser to the start of a line. No clearing pass.
module decimal_expression_calculator_unit import dxc_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 20
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         char_valid,
  output logic         char_stall,
  input  char_item_t   char_item,
  output logic         res_valid,
  input  logic         res_stall,
  output result_item_t res_item
);

  // Parser to queue
  logic      push;
  job_t      push_job;
  // Queue to execution unit
  logic      pop;
  job_t      pop_job;
  q_status_t q_stat;

  // Front: classify characters, accumulate numbers, push one job per line
  dxc_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_item (char_item),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // Decouple parser and execution so each can stall on its own
  dxc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .pop_job (pop_job),
    .q_stat  (q_stat)
  );

  // Back: run the checked arithmetic and hold the result until taken
  dxc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .pop_job  (pop_job),
    .pop      (pop),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item (res_item)
  );

endmodule
